@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/sclp_pkg.sv @@
// ----------------------------------------------------------------------------
// sclp_pkg
// types, calibration tables and constants of the calibrate and lowpass block
// ----------------------------------------------------------------------------
`default_nettype none

package sclp_pkg;

    // fixed formats
    localparam int TABLE_POINTS = 7;
    localparam int FRAC_BITS    = 16;   // distance fraction bits, metres in q16
    localparam int CH_W         = 3;
    localparam int RAW_W        = 16;
    localparam int ALPHA_W      = 16;
    localparam int DIST_W       = 18;
    localparam int SEG_W        = 3;
    localparam int OFF_W        = 13;   // widest segment spans 6300 codes
    localparam int SLOPE_W      = 20;
    localparam int SLOPE_FRAC   = 16;
    localparam int PROD_W       = OFF_W + SLOPE_W;
    localparam int BLEND_W      = ALPHA_W + 1 + DIST_W;

    // request queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int PTR_W        = 1;
    localparam int LEVEL_W      = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd2027;
    localparam logic [ALPHA_W:0]   ALPHA_ONE   = 17'h10000;
    localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

    typedef logic signed [RAW_W-1:0] code_t;

    // breakpoints in converter code units
    localparam code_t CAL_CODE [TABLE_POINTS] = '{
        16'sd64, 16'sd1000, 16'sd1979, 16'sd2820, 16'sd3757, 16'sd4640, 16'sd10940
    };

    // breakpoint distances, micrometres rounded to q16 metres
    localparam logic [DIST_W-1:0] CAL_Y [TABLE_POINTS] = '{
        18'd5308, 18'd18874, 18'd32834, 18'd44958, 18'd57999, 18'd71107, 18'd160301
    };

    // segment slopes, distance lsb per code with 16 extra fraction bits,
    // last entry unused (clamped region)
    localparam logic [SLOPE_W-1:0] CAL_SLOPE [TABLE_POINTS] = '{
        20'd949852, 20'd934507, 20'd944778, 20'd912118, 20'd972872, 20'd927844, 20'd0
    };

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SEG_W-1:0] seg;
        logic [OFF_W-1:0] off;
    } sclp_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_FILT,
        BK_DONE
    } sclp_back_state_t;

    typedef struct packed {
        logic busy;
        logic result_load;
    } sclp_back_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sclp_front.sv @@
// ----------------------------------------------------------------------------
// sclp_front
// finds the calibration segment of each request and queues it for the back
// ----------------------------------------------------------------------------
`default_nettype none

module sclp_front import sclp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [CH_W-1:0]   channel,
    input  wire logic [RAW_W-1:0]  raw_code,
    output logic                   full,
    input  wire logic              q_pop,
    output sclp_item_t             q_item,
    output logic                   q_valid,
    output logic [LEVEL_W-1:0]     q_level
);

    sclp_item_t          item_c;
    code_t               code_c;
    logic [RAW_W:0]      diff_c;
    logic                push_fire;
    logic                pop_fire;

    sclp_item_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;

    // segment search, clamped at both ends
    always_comb
    begin
        code_c         = code_t'(raw_code);
        item_c.channel = channel;
        item_c.seg     = '0;
        item_c.off     = '0;
        diff_c         = '0;
        priority if (code_c <= CAL_CODE[0])
        begin
            item_c.seg = '0;
        end
        else if (code_c >= CAL_CODE[TABLE_POINTS-1])
        begin
            item_c.seg = SEG_W'(TABLE_POINTS - 1);
        end
        else
        begin
            for (int i = 1; i < TABLE_POINTS - 1; i++)
            begin
                if (code_c >= CAL_CODE[i])
                begin
                    item_c.seg = SEG_W'(i);
                end
            end
            diff_c     = {code_c[RAW_W-1], code_c}
                       - {CAL_CODE[item_c.seg][RAW_W-1], CAL_CODE[item_c.seg]};
            item_c.off = diff_c[OFF_W-1:0];
        end
    end

    assign full      = (level_reg == LEVEL_W'(QUEUE_DEPTH));
    assign q_valid   = (level_reg != '0);
    assign push_fire = push && !full;
    assign pop_fire  = q_pop && q_valid;
    assign q_item    = mem_reg[rd_ptr_reg];
    assign q_level   = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= item_c;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sclp_back.sv @@
// ----------------------------------------------------------------------------
// sclp_back
// interpolates, runs the per-channel lowpass and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module sclp_back import sclp_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [ALPHA_W-1:0]  alpha,
    input  wire logic                q_valid,
    input  wire sclp_item_t          q_item,
    output logic                     q_pop,
    input  wire logic                out_pop,
    output logic                     out_valid,
    output logic [CH_W-1:0]          out_channel,
    output logic [DIST_W-1:0]        calibrated_distance,
    output logic [DIST_W-1:0]        filtered_distance,
    output sclp_back_status_t        status
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    sclp_back_state_t    state_reg, state_next;
    sclp_item_t          item_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DIST_W-1:0]   y0_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [DIST_W-1:0]   old_reg;
    logic [BLEND_W-1:0]  blend_a_reg;
    logic [BLEND_W-1:0]  blend_b_reg;
    logic [DIST_W-1:0]   filt_reg [CHANNELS];
    logic                out_valid_reg, out_valid_next;
    logic [CH_W-1:0]     out_channel_reg;
    logic [DIST_W-1:0]   out_cal_reg;
    logic [DIST_W-1:0]   out_filt_reg;

    logic [CH_W-1:0]     ch_mod_c;
    logic [IDX_W-1:0]    idx_c;
    logic [DIST_W:0]     dist_sum_c;
    logic [DIST_W-1:0]   dist_c;
    logic [BLEND_W-1:0]  blend_sum_c;
    logic [DIST_W-1:0]   filt_c;
    logic                load_c;

    // channel folded onto the state entries
    always_comb
    begin
        ch_mod_c = item_reg.channel;
        for (int k = 0; k < (1 << CH_W) - 1; k++)
        begin
            if (int'(ch_mod_c) >= CHANNELS)
            begin
                ch_mod_c = ch_mod_c - CH_W'(CHANNELS);
            end
        end
        idx_c = IDX_W'(ch_mod_c);
    end

    assign dist_sum_c  = {1'b0, y0_reg} + (DIST_W + 1)'(prod_reg[PROD_W-1:SLOPE_FRAC]);
    assign dist_c      = dist_sum_c[DIST_W] ? DIST_MAX : dist_sum_c[DIST_W-1:0];
    assign blend_sum_c = blend_a_reg + blend_b_reg;
    assign filt_c      = blend_sum_c[ALPHA_W +: DIST_W];

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_c     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:  state_next = BK_ADD;
            BK_ADD:  state_next = BK_FILT;
            BK_FILT: state_next = BK_DONE;
            BK_DONE:
            begin
                load_c = !out_valid_reg || out_pop;
                if (load_c)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_c)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // lowpass state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                filt_reg[c] <= '0;
            end
        end
        else if (load_c)
        begin
            filt_reg[idx_c] <= filt_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == BK_MUL)
        begin
            prod_reg <= PROD_W'(item_reg.off) * PROD_W'(CAL_SLOPE[item_reg.seg]);
            y0_reg   <= CAL_Y[item_reg.seg];
        end
        if (state_reg == BK_ADD)
        begin
            dist_reg <= dist_c;
            old_reg  <= filt_reg[idx_c];
        end
        if (state_reg == BK_FILT)
        begin
            blend_a_reg <= BLEND_W'(alpha) * BLEND_W'(dist_reg);
            blend_b_reg <= BLEND_W'(ALPHA_ONE - {1'b0, alpha}) * BLEND_W'(old_reg);
        end
        if (load_c)
        begin
            out_channel_reg <= item_reg.channel;
            out_cal_reg     <= dist_reg;
            out_filt_reg    <= filt_c;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_channel         = out_channel_reg;
    assign calibrated_distance = out_cal_reg;
    assign filtered_distance   = out_filt_reg;
    assign status.busy         = (state_reg != BK_IDLE);
    assign status.result_load  = load_c;

endmodule

`default_nettype wire

@@ rtl/core/sensor_calibrate_and_lowpass_top.sv @@
// ----------------------------------------------------------------------------
// sensor_calibrate_and_lowpass_top
// piecewise-linear sensor calibration followed by a per-channel lowpass
// ----------------------------------------------------------------------------
// usage
//   input queue: drive channel and raw_code with push; a request is taken on
//     a clock edge with push high and full low
//   result queue: while empty is low the oldest result is on out_channel,
//     calibrated_distance and filtered_distance; pop takes it
//   cfg_write with cfg_data loads filter_alpha (q0.16); write
//     it only while no request is in flight
// timing
//   front classifies in the accept cycle and parks the request in a 2-entry
//   queue; the back runs a 5-step sequencer (pop, multiply, add, blend,
//   write back); it pops a new request only from idle, after the write back
//   of the last one; the write back waits while a result is unpopped; this
//   sequence, with the per-channel state read-modify-write in it, sets the rate
// reset
//   queues empty, all channel lowpass states zero, filter_alpha 2027
// stall
//   a waiting result sits in the output register; the back finishes its
//   next request and waits, the queue fills and full rises
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sensor_calibrate_and_lowpass_top import sclp_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input queue side
    input  wire logic                push,
    output logic                     full,
    input  wire logic [CH_W-1:0]     channel,
    input  wire logic [RAW_W-1:0]    raw_code,
    // result queue side
    output logic                     empty,
    input  wire logic                pop,
    output logic [CH_W-1:0]          out_channel,
    output logic [DIST_W-1:0]        calibrated_distance,
    output logic [DIST_W-1:0]        filtered_distance,
    // filter_alpha register
    input  wire logic                cfg_write,
    input  wire logic [ALPHA_W-1:0]  cfg_data
);

    logic [ALPHA_W-1:0]  alpha_reg;
    sclp_item_t          q_item;
    logic                q_valid;
    logic                q_pop;
    logic [LEVEL_W-1:0]  q_level;
    logic                out_valid;
    logic                out_pop;
    sclp_back_status_t   back_status;

    // lowpass weight of the new sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            alpha_reg <= cfg_data;
        end
    end

    // accept side: segment search and request queue
    sclp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .channel  (channel),
        .raw_code (raw_code),
        .full     (full),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_level  (q_level)
    );

    assign empty   = !out_valid;
    assign out_pop = pop && out_valid;

    // execute side: interpolation, lowpass and result register
    sclp_back #(
        .CHANNELS (CHANNELS)
    ) u_back
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .alpha               (alpha_reg),
        .q_valid             (q_valid),
        .q_item              (q_item),
        .q_pop               (q_pop),
        .out_pop             (out_pop),
        .out_valid           (out_valid),
        .out_channel         (out_channel),
        .calibrated_distance (calibrated_distance),
        .filtered_distance   (filtered_distance),
        .status              (back_status)
    );

    // a finished request shows up on the result side next cycle
    `ASSERT_NEXT(a_result_after_load, clk, rst_n, back_status.result_load, !empty)
    // a waiting result is never overwritten
    `ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(back_status.result_load && !empty && !pop))
    // results are only loaded by a running sequencer
    `ASSERT_ALWAYS(a_load_busy, clk, rst_n, !back_status.result_load || back_status.busy)
    // request queue stays within its depth
    `ASSERT_ALWAYS(a_queue_level, clk, rst_n, q_level <= LEVEL_W'(QUEUE_DEPTH))
    // interpolation never passes the last breakpoint distance
    `ASSERT_ALWAYS(a_distance_range, clk, rst_n, empty || (calibrated_distance <= CAL_Y[TABLE_POINTS-1]))

endmodule

`default_nettype wire
